// ===== hdl/rbst_pkg.sv =====
// package for the ray box slab test: defaults, widths and register indexes
`default_nettype none
package rbst_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_INDEX_W     = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5
    } cfg_reg_t;
endpackage
`default_nettype wire

// ===== hdl/rbst_slab_div.sv =====
// pipelined saturating fixed-point divider for one slab distance
`default_nettype none
module rbst_slab_div #(
    parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF
) (
    input  wire                           aclk,
    input  wire                           en,
    input  wire signed [COORD_WIDTH-1:0]  corner,
    input  wire signed [COORD_WIDTH-1:0]  origin,
    input  wire signed [COORD_WIDTH-1:0]  direction,
    output logic signed [COORD_WIDTH-1:0] t_out
);
    localparam int W      = COORD_WIDTH;
    localparam int NW     = 2 * COORD_WIDTH + FRAC_BITS;
    localparam int STAGES = COORD_WIDTH - 1;

    logic [W:0]    gap_next, gap_neg;
    logic [W:0]    dir_ext, dir_neg;
    logic [W-1:0]  gmag_next, dmag_next;
    logic [NW-1:0] num_next, satlim;
    logic          gneg, dneg, sat_next;

    always_comb begin
        gap_next  = {corner[W-1], corner} - {origin[W-1], origin};
        gap_neg   = -gap_next;
        gneg      = gap_next[W];
        gmag_next = gneg ? gap_neg[W-1:0] : gap_next[W-1:0];
        dir_ext   = {direction[W-1], direction};
        dir_neg   = -dir_ext;
        dneg      = direction[W-1];
        dmag_next = dneg ? dir_neg[W-1:0] : direction;
        num_next  = NW'(gmag_next) << FRAC_BITS;
        satlim    = NW'(dmag_next) << (W - 1);
        sat_next  = num_next >= satlim;
    end

    logic [NW-1:0]     r_reg    [0:STAGES-1];
    logic [W-1:0]      d_reg    [0:STAGES-1];
    logic [STAGES-1:0] q_reg    [0:STAGES];
    logic              neg_reg  [0:STAGES];
    logic              sat_reg  [0:STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= num_next;
            d_reg[0]   <= dmag_next;
            q_reg[0]   <= '0;
            neg_reg[0] <= gneg ^ dneg;
            sat_reg[0] <= sat_next;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam int B = STAGES - 1 - k;
        logic [NW-1:0]     dsh;
        logic              take;
        logic [STAGES-1:0] q_next;
        always_comb begin
            dsh       = NW'(d_reg[k]) << B;
            take      = r_reg[k] >= dsh;
            q_next    = q_reg[k];
            q_next[B] = take;
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k+1]   <= q_next;
                neg_reg[k+1] <= neg_reg[k];
                sat_reg[k+1] <= sat_reg[k];
            end
        end
        if (k < STAGES - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k+1] <= take ? (r_reg[k] - dsh) : r_reg[k];
                    d_reg[k+1] <= d_reg[k];
                end
            end
        end
    end

    logic [W-1:0] q_ext, t_next;
    always_comb begin
        q_ext = {1'b0, q_reg[STAGES]};
        if (!neg_reg[STAGES]) begin
            t_next = sat_reg[STAGES] ? {1'b0, {(W-1){1'b1}}} : q_ext;
        end else begin
            t_next = sat_reg[STAGES] ? {1'b1, {(W-1){1'b0}}} : -q_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_out <= t_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ray_box_slab_test_core.sv =====
// top level: streaming ray versus axis-aligned box slab test
//
// Takes one ray per transfer (origin and direction, signed fixed point with
// FRAC_BITS fraction bits) and returns one hit flag per ray, in order. The box
// corners come from six registers on the write port; write them only while
// the block is idle. While the output is not stalled, rays may follow each
// other in every cycle and the block sustains one ray per cycle. The pipeline
// is made of the six dividers that produce one quotient bit per pipeline
// stage, plus a front stage, an output stage of each divider and three
// stages of slab ordering and interval narrowing. A stalled output holds the
// whole pipeline.
`default_nettype none
module ray_box_slab_test_core #(
    parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // box corner registers
    input  wire                              cfg_wr_en,
    input  wire [rbst_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire [COORD_WIDTH-1:0]            cfg_wr_data,
    // ray input
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
    input  wire [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // result
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // hit
    output logic [7:0]                       m_tdata
);
    localparam int W       = COORD_WIDTH;
    localparam int DIV_LAT = COORD_WIDTH + 1;

    // box corners, index order: min x y z, max x y z
    logic signed [W-1:0] box_reg [0:5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) box_reg[i] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rbst_pkg::REG_BOX_MIN_X: box_reg[0] <= cfg_wr_data;
                rbst_pkg::REG_BOX_MIN_Y: box_reg[1] <= cfg_wr_data;
                rbst_pkg::REG_BOX_MIN_Z: box_reg[2] <= cfg_wr_data;
                rbst_pkg::REG_BOX_MAX_X: box_reg[3] <= cfg_wr_data;
                rbst_pkg::REG_BOX_MAX_Y: box_reg[4] <= cfg_wr_data;
                rbst_pkg::REG_BOX_MAX_Z: box_reg[5] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // global advance: every stage moves when the output slot is free or taken
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic signed [W-1:0] org [0:2];
    logic signed [W-1:0] dir [0:2];
    logic signed [W-1:0] t0  [0:2];
    logic signed [W-1:0] t1  [0:2];
    logic [2:0] zero_next, out_next;

    // zero direction: infinite slab when origin sits between the corners
    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign org[a] = s_tdata[a*W +: W];
        assign dir[a] = s_tdata[(a+3)*W +: W];
        always_comb begin
            zero_next[a] = dir[a] == '0;
            out_next[a]  = !(((org[a] >= box_reg[a]) && (org[a] <= box_reg[a+3])) ||
                             ((org[a] >= box_reg[a+3]) && (org[a] <= box_reg[a])));
        end
        rbst_slab_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_lo (
            .aclk(aclk), .en(en), .corner(box_reg[a]), .origin(org[a]),
            .direction(dir[a]), .t_out(t0[a])
        );
        rbst_slab_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_hi (
            .aclk(aclk), .en(en), .corner(box_reg[a+3]), .origin(org[a]),
            .direction(dir[a]), .t_out(t1[a])
        );
    end

    // side flags and valid bits that travel alongside the dividers
    logic [DIV_LAT-1:0] vld_reg;
    logic [2:0]         zero_reg [0:DIV_LAT-1];
    logic [2:0]         out_reg  [0:DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= zero_next;
            out_reg[0]  <= out_next;
            for (int i = 1; i < DIV_LAT; i++) begin
                zero_reg[i] <= zero_reg[i-1];
                out_reg[i]  <= out_reg[i-1];
            end
        end
    end

    localparam logic signed [W-1:0] T_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] T_MAX = {1'b0, {(W-1){1'b1}}};

    // stage p1: ordered interval per axis
    logic signed [W-1:0] lo_reg [0:2];
    logic signed [W-1:0] hi_reg [0:2];
    logic                p1_miss_reg, p1_vld_reg;
    logic                p1_miss_next;

    always_comb begin
        p1_miss_next = |(zero_reg[DIV_LAT-1] & out_reg[DIV_LAT-1]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_miss_reg <= p1_miss_next;
            for (int a = 0; a < 3; a++) begin
                if (zero_reg[DIV_LAT-1][a]) begin
                    lo_reg[a] <= T_MIN;
                    hi_reg[a] <= T_MAX;
                end else if (t0[a] > t1[a]) begin
                    lo_reg[a] <= t1[a];
                    hi_reg[a] <= t0[a];
                end else begin
                    lo_reg[a] <= t0[a];
                    hi_reg[a] <= t1[a];
                end
            end
        end
    end

    // stage p2: merge x and y
    logic signed [W-1:0] xy_lo_reg, xy_hi_reg, z_lo_reg, z_hi_reg;
    logic                p2_miss_reg, p2_vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_miss_reg <= p1_miss_reg || (lo_reg[0] > hi_reg[1]) || (lo_reg[1] > hi_reg[0]);
            xy_hi_reg   <= (hi_reg[0] < hi_reg[1]) ? hi_reg[0] : hi_reg[1];
            xy_lo_reg   <= (lo_reg[0] > lo_reg[1]) ? lo_reg[0] : lo_reg[1];
            z_lo_reg    <= lo_reg[2];
            z_hi_reg    <= hi_reg[2];
        end
    end

    // stage p3: merge z, exit must lie ahead of the origin
    logic signed [W-1:0] fin_hi;
    logic                hit_next;

    always_comb begin
        fin_hi   = (xy_hi_reg > z_hi_reg) ? z_hi_reg : xy_hi_reg;
        hit_next = !(p2_miss_reg || (xy_lo_reg > z_hi_reg) || (z_lo_reg > xy_hi_reg)) &&
                   (fin_hi > 0);
    end

    logic hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            m_tvalid   <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= vld_reg[DIV_LAT-1];
            p2_vld_reg <= p1_vld_reg;
            m_tvalid   <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= hit_next;
        end
    end

    assign m_tdata = {7'd0, hit_reg};

`ifndef SYNTHESIS
    // a stalled result stays on offer
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    // a result that leaves the last stage reaches the output
    a_last_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && p2_vld_reg) |=> m_tvalid)
        else $error("result lost at output stage");

    // a known miss never turns into a hit
    a_miss_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && p2_vld_reg && p2_miss_reg) |=> !m_tdata[0])
        else $error("missed slab reported as hit");

    // nothing comes out of an empty pipeline
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && !p2_vld_reg) |=> !m_tvalid)
        else $error("result without an input");
`endif
endmodule
`default_nettype wire
